### hw/rtl/modbus_tcp_client_framer_macros.svh
// ----------------------------------------------------------------------------
// modbus tcp client framer assertion macros
// shared property wrappers for the framer assertions
// ----------------------------------------------------------------------------
`ifndef MODBUS_TCP_CLIENT_FRAMER_MACROS_SVH
`define MODBUS_TCP_CLIENT_FRAMER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define MBTCP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mbtcp assertion failed");

// next-cycle implication, disabled while in reset
`define MBTCP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mbtcp assertion failed");

`endif

### hw/rtl/mbtcp_pkg.sv
// ----------------------------------------------------------------------------
// mbtcp package
// types and constants of the modbus tcp client framer
// ----------------------------------------------------------------------------
`default_nettype none

package mbtcp_pkg;

  // largest accepted response frame, mbap header included
  localparam int MAX_FRAME_BYTES = 260;

  localparam logic [7:0] UNIT_ID_RESET = 8'd1;
  localparam logic [7:0] EXC_BIT       = 8'h80;
  localparam logic [7:0] PROTO_ID_BYTE = 8'h00;

  typedef enum logic [1:0] {
    MODE_REQUEST = 2'd0,
    MODE_RX_BYTE = 2'd1,
    MODE_ABORT   = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    KIND_TX_BYTE = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_STATUS  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ID_MISM   = 3'd1,
    ST_PROTO     = 3'd2,
    ST_UNIT_MISM = 3'd3,
    ST_EXCEPTION = 3'd4,
    ST_OVERSIZE  = 3'd5,
    ST_ABORTED   = 3'd6
  } status_t;

  // one non-header result
  typedef struct packed {
    kind_t       kind;
    logic [15:0] value;
    logic        is_bits;
    status_t     status;
    logic [7:0]  exc;
    logic        last;
  } res_t;

endpackage

`default_nettype wire

### hw/rtl/modbus_tcp_client_framer.sv
// path: an input item is taken into the input register, then into the result bundle register that drives the output
// throughput: one response byte per cycle while out_tready stays high and no byte yields two
//   results; a request holds the input while its 8 header bytes go out one per output transfer
// rate is set by the single result bundle register behind the step logic
// reset: rst_n synchronous active low, clears all frame state and the
//   transaction counter, unit_id returns to 1
// ----------------------------------------------------------------------------
// modbus tcp client framer
// builds mbap request headers and checks and unpacks response frames
// ----------------------------------------------------------------------------
`default_nettype none

`include "modbus_tcp_client_framer_macros.svh"

module modbus_tcp_client_framer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration: unit identifier
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_wdata,
  // input channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // rx_byte[7:0], function_code[15:8], data_length[23:16]
  input  wire logic [1:0]  in_tuser,   // mode[1:0]
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // tx_byte[7:0], payload_value[23:8], status[26:24],
                                       // exception_code[34:27], zero[39:35]
  output logic [2:0]       out_tuser,  // kind[1:0], payload_is_bits[2]
  output logic             out_tlast
);

  import mbtcp_pkg::*;

  localparam logic [16:0] MAX_LEN = 17'(MAX_FRAME_BYTES);

  // configuration register
  logic [7:0]  unit_r;

  // input register stage
  logic        in_valid_r;
  mode_t       in_mode_r;
  logic [7:0]  in_rx_r;
  logic [7:0]  in_fc_r;
  logic [7:0]  in_dlen_r;

  // frame state
  logic [15:0] ntid_r, ntid_nxt;
  logic        await_r, await_nxt;
  logic [8:0]  pos_r, pos_nxt;
  logic [7:0]  tid_hi_r, tid_hi_nxt;
  logic [15:0] flen_r, flen_nxt;
  logic [7:0]  rfunc_r, rfunc_nxt;
  status_t     ferr_r, ferr_nxt;
  logic [7:0]  prem_r, prem_nxt;
  logic [7:0]  hold_r, hold_nxt;

  // result bundle register: either an 8 byte header burst or up to 2 results
  logic [3:0]  cnt_r, cnt_nxt;
  logic        is_hdr_r, is_hdr_nxt;
  logic [63:0] hdr_r, hdr_nxt;
  res_t        res0_r, res0_nxt;
  res_t        res1_r, res1_nxt;

  // step scratch
  logic        emit_pay;
  logic        emit_fin;
  res_t        pay_res;
  res_t        fin_res;
  logic        oversize;
  logic [16:0] end_pos;
  logic [8:0]  req_len;
  logic [15:0] req_tid;

  logic        load;
  logic        in_fire;
  logic        out_fire;

  // handshakes: the input register frees up when the bundle takes its item
  assign out_tvalid = (cnt_r != 4'd0);
  assign out_fire   = out_tvalid && out_tready;
  assign load       = in_valid_r && ((cnt_r == 4'd0) || ((cnt_r == 4'd1) && out_tready));
  assign in_tready  = !in_valid_r || load;
  assign in_fire    = in_tvalid && in_tready;

  // step logic for the item in the input register
  always_comb begin
    ntid_nxt   = ntid_r;
    await_nxt  = await_r;
    pos_nxt    = pos_r;
    tid_hi_nxt = tid_hi_r;
    flen_nxt   = flen_r;
    rfunc_nxt  = rfunc_r;
    ferr_nxt   = ferr_r;
    prem_nxt   = prem_r;
    hold_nxt   = hold_r;
    emit_pay   = 1'b0;
    emit_fin   = 1'b0;
    oversize   = 1'b0;
    pay_res    = '0;
    fin_res    = '0;
    req_len    = 9'({1'b0, in_dlen_r} + 9'd2);
    req_tid    = ntid_r;
    is_hdr_nxt = 1'b0;
    hdr_nxt    = {in_fc_r, unit_r, req_len[7:0], {7'd0, req_len[8]},
                  PROTO_ID_BYTE, PROTO_ID_BYTE, req_tid[7:0], req_tid[15:8]};
    end_pos    = 17'd6 + {1'b0, flen_r};

    case (in_mode_r)
      MODE_REQUEST: begin
        // fresh frame, any frame in progress is dropped silently
        is_hdr_nxt = 1'b1;
        ntid_nxt   = ntid_r + 16'd1;
        await_nxt  = 1'b1;
        pos_nxt    = '0;
        tid_hi_nxt = '0;
        flen_nxt   = '0;
        rfunc_nxt  = '0;
        ferr_nxt   = ST_OK;
        prem_nxt   = '0;
        hold_nxt   = '0;
      end
      MODE_ABORT: begin
        if (await_r) begin
          ferr_nxt = ST_ABORTED;
          hold_nxt = '0;
          emit_fin = 1'b1;
        end
      end
      MODE_RX_BYTE: begin
        if (await_r) begin
          case (pos_r)
            9'd0: tid_hi_nxt = in_rx_r;
            9'd1: begin
              if ({tid_hi_r, in_rx_r} != (ntid_r - 16'd1) && ferr_r == ST_OK) begin
                ferr_nxt = ST_ID_MISM;
              end
            end
            9'd2, 9'd3: begin
              if (in_rx_r != PROTO_ID_BYTE && ferr_r == ST_OK) begin
                ferr_nxt = ST_PROTO;
              end
            end
            9'd4: flen_nxt = {in_rx_r, 8'd0};
            9'd5: begin
              flen_nxt = {flen_r[15:8], in_rx_r};
              // oversize ends the frame at once and overrides earlier errors
              if ((17'd6 + {1'b0, flen_r[15:8], in_rx_r}) > MAX_LEN) begin
                oversize = 1'b1;
                ferr_nxt = ST_OVERSIZE;
                hold_nxt = '0;
              end
            end
            9'd6: begin
              if (in_rx_r != unit_r && ferr_r == ST_OK) begin
                ferr_nxt = ST_UNIT_MISM;
              end
            end
            9'd7: begin
              rfunc_nxt = in_rx_r;
              if ((in_rx_r & EXC_BIT) != 8'd0 && ferr_r == ST_OK) begin
                ferr_nxt = ST_EXCEPTION;
              end
            end
            9'd8: begin
              // byte count, or the exception code
              if ((rfunc_r & EXC_BIT) != 8'd0) begin
                if (ferr_r == ST_EXCEPTION) begin
                  hold_nxt = in_rx_r;
                end
              end else if (rfunc_r inside {[8'd1:8'd4]}) begin
                prem_nxt = in_rx_r;
              end
            end
            default: begin
              if (prem_r != 8'd0) begin
                prem_nxt = prem_r - 8'd1;
                if (rfunc_r == 8'd1 || rfunc_r == 8'd2) begin
                  // coil or discrete input bits, one byte at a time
                  if (ferr_r == ST_OK) begin
                    emit_pay        = 1'b1;
                    pay_res.kind    = KIND_PAYLOAD;
                    pay_res.value   = {8'd0, in_rx_r};
                    pay_res.is_bits = 1'b1;
                  end
                end else if (pos_r[0]) begin
                  hold_nxt = in_rx_r;
                end else if (ferr_r == ST_OK) begin
                  // big-endian register word
                  emit_pay      = 1'b1;
                  pay_res.kind  = KIND_PAYLOAD;
                  pay_res.value = {hold_r, in_rx_r};
                end
              end
            end
          endcase

          end_pos = 17'd6 + {1'b0, flen_nxt};
          if (oversize) begin
            emit_fin = 1'b1;
          end else begin
            pos_nxt = pos_r + 9'd1;
            if (pos_r >= 9'd5 && ({8'd0, pos_r} + 17'd1) >= end_pos) begin
              emit_fin = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase

    if (emit_fin) begin
      await_nxt      = 1'b0;
      fin_res.kind   = KIND_STATUS;
      fin_res.status = ferr_nxt;
      fin_res.exc    = (ferr_nxt == ST_EXCEPTION) ? hold_nxt : 8'd0;
      fin_res.last   = 1'b1;
    end

    // pack the results into the bundle, payload first
    if (is_hdr_nxt) begin
      cnt_nxt  = 4'd8;
      res0_nxt = '0;
      res1_nxt = '0;
    end else if (emit_pay) begin
      cnt_nxt  = emit_fin ? 4'd2 : 4'd1;
      res0_nxt = pay_res;
      res1_nxt = fin_res;
    end else begin
      cnt_nxt  = emit_fin ? 4'd1 : 4'd0;
      res0_nxt = fin_res;
      res1_nxt = '0;
    end
  end

  // output view of the bundle head
  always_comb begin
    if (is_hdr_r) begin
      out_tdata = {5'd0, 8'd0, ST_OK, 16'd0, hdr_r[7:0]};
      out_tuser = {1'b0, KIND_TX_BYTE};
      out_tlast = (cnt_r == 4'd1);
    end else begin
      out_tdata = {5'd0, res0_r.exc, res0_r.status, res0_r.value, 8'd0};
      out_tuser = {res0_r.is_bits, res0_r.kind};
      out_tlast = res0_r.last;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_r     <= UNIT_ID_RESET;
      in_valid_r <= 1'b0;
      ntid_r     <= '0;
      await_r    <= 1'b0;
      pos_r      <= '0;
      tid_hi_r   <= '0;
      flen_r     <= '0;
      rfunc_r    <= '0;
      ferr_r     <= ST_OK;
      prem_r     <= '0;
      hold_r     <= '0;
      cnt_r      <= '0;
      is_hdr_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unit_r <= cfg_wdata;
      end
      in_valid_r <= in_fire || (in_valid_r && !load);
      if (load) begin
        ntid_r   <= ntid_nxt;
        await_r  <= await_nxt;
        pos_r    <= pos_nxt;
        tid_hi_r <= tid_hi_nxt;
        flen_r   <= flen_nxt;
        rfunc_r  <= rfunc_nxt;
        ferr_r   <= ferr_nxt;
        prem_r   <= prem_nxt;
        hold_r   <= hold_nxt;
        cnt_r    <= cnt_nxt;
        is_hdr_r <= is_hdr_nxt;
      end else if (out_fire) begin
        cnt_r <= cnt_r - 4'd1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_mode_r <= mode_t'(in_tuser[1:0]);
      in_rx_r   <= in_tdata[7:0];
      in_fc_r   <= in_tdata[15:8];
      in_dlen_r <= in_tdata[23:16];
    end
    if (load) begin
      hdr_r  <= hdr_nxt;
      res0_r <= res0_nxt;
      res1_r <= res1_nxt;
    end else if (out_fire) begin
      hdr_r  <= {8'd0, hdr_r[63:8]};
      res0_r <= res1_r;
    end
  end

  // bundle never holds more than a header burst
  `MBTCP_ASSERT_NOW(a_cnt_range, clk, rst_n, 1'b1, cnt_r <= 4'd8)
  // non-header bundles carry at most a payload and a status
  `MBTCP_ASSERT_NOW(a_res_cnt, clk, rst_n, !is_hdr_r, cnt_r <= 4'd2)
  // a request always starts a full header burst
  `MBTCP_ASSERT_NEXT(a_req_burst, clk, rst_n, load && in_mode_r == MODE_REQUEST,
                     is_hdr_r && cnt_r == 4'd8 && await_r)
  // status items always close a run
  `MBTCP_ASSERT_NOW(a_status_last, clk, rst_n, out_tvalid && out_tuser[1:0] == KIND_STATUS,
                    out_tlast)
  // a status item ends the frame wait
  `MBTCP_ASSERT_NEXT(a_fin_idle, clk, rst_n, load && emit_fin, !await_r)

endmodule

`default_nettype wire
